>>> design/lie_pkg.sv
`default_nettype none

package lie_pkg;

    // Node table geometry.
    localparam int MAX_NODES = 8;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    // Q16.16 data and the wider internal formats.
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int CFG_W   = 4;
    localparam int DIFF_W  = DATA_W + 1;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int RND_W   = PROD_W - FRAC_W + 1;
    localparam int SUM_W   = 52;
    localparam int NODE_W  = 2 * DATA_W;

    // Divider geometry: dividend is 2*|diff|*2^16 + |den|, divisor is 2*|den|.
    localparam int DVD_W   = DIFF_W + FRAC_W + 2;
    localparam int DSR_W   = DIFF_W + 1;
    localparam int REM_W   = DSR_W + 1;
    localparam int DCNT_W  = $clog2(DVD_W + 1);

    localparam logic [CFG_W-1:0]  NODE_COUNT_RST = CFG_W'(5);
    localparam logic signed [DATA_W-1:0] ONE_Q16 = DATA_W'(65536);

    // Input actions.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_DUP = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    // Divider result handed back to the sequencer.
    typedef struct packed {
        logic             done;
        logic             neg;
        logic [DVD_W-1:0] quo;
    } div_res_t;

    // Round a Q32.32 product back to Q16.16, ties away from zero.
    function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] s;
        logic [RND_W-2:0]  r;
        m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        s = (m + PROD_W'(32768)) >> FRAC_W;
        r = s[RND_W-2:0];
        return p[PROD_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    // Clamp to the signed 32-bit range; the top bit flags a clamp.
    function automatic logic [DATA_W:0] clamp32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sd2147483647);
        lo = -SUM_W'(64'sd2147483648);
        if (v > hi)
            return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        else if (v < lo)
            return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, v[DATA_W-1:0]};
    endfunction

endpackage

`default_nettype wire

>>> design/lie_if.sv
`default_nettype none

// Input channel: one beat loads a node or requests an evaluation.
interface lie_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [2:0]                node_index;
    logic signed [31:0]        point_x;
    logic signed [31:0]        node_value;

    modport source (output valid, action, node_index, point_x, node_value, input ready);
    modport sink   (input valid, action, node_index, point_x, node_value, output ready);
endinterface

// Output channel: one beat per evaluation.
interface lie_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [31:0]        interp_value;
    logic [1:0]                status;

    modport source (output valid, interp_value, status, input ready);
    modport sink   (input valid, interp_value, status, output ready);
endinterface

`default_nettype wire

>>> design/lie_ram.sv
`default_nettype none

module lie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/lie_div.sv
`default_nettype none

module lie_div
    import lie_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DIFF_W-1:0] num_diff,
    input  wire logic signed [DIFF_W-1:0] den_diff,
    output div_res_t                      res
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic              neg_reg, neg_next;

    logic [DIFF_W-1:0] un;
    logic [DIFF_W-1:0] ud;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // Magnitudes of the operands.
    assign un = num_diff[DIFF_W-1] ? DIFF_W'(-num_diff) : DIFF_W'(num_diff);
    assign ud = den_diff[DIFF_W-1] ? DIFF_W'(-den_diff) : DIFF_W'(den_diff);

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DVD_W);
            dvd_next  = (DVD_W'({un, {FRAC_W{1'b0}}}) << 1) + DVD_W'(ud);
            dsr_next  = {ud, 1'b0};
            rem_next  = '0;
            quo_next  = '0;
            neg_next  = num_diff[DIFF_W-1] ^ den_diff[DIFF_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? REM_W'(trial - {1'b0, dsr_reg}) : trial;
            quo_next = {quo_reg[DVD_W-2:0], fits};
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign res = '{done: done_reg, neg: neg_reg, quo: quo_reg};

endmodule

`default_nettype wire

>>> design/lagrange_interpolation_eval.sv
// Lagrange evaluator over up to eight Q16.16 nodes, one item at a time.
// Each basis factor of an evaluate beat goes through the 51-step radix-2 divider.
// The result then waits in an output register; input is not ready until it is taken.
// Reset clears the sequencer and sets node_count to 5; the node table is undefined until loaded.
`default_nettype none

module lagrange_interpolation_eval
    import lie_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    lie_in_if.sink                item,
    lie_out_if.source             result,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_DUP_I   = 15'b000000000000010,
        ST_DUP_J   = 15'b000000000000100,
        ST_DUP_CMP = 15'b000000000001000,
        ST_EV_I    = 15'b000000000010000,
        ST_EV_XI   = 15'b000000000100000,
        ST_EV_J    = 15'b000000001000000,
        ST_EV_XJ   = 15'b000000010000000,
        ST_DIV     = 15'b000000100000000,
        ST_MUL_B   = 15'b000001000000000,
        ST_RND_B   = 15'b000010000000000,
        ST_MUL_T   = 15'b000100000000000,
        ST_RND_T   = 15'b001000000000000,
        ST_FIN     = 15'b010000000000000,
        ST_OUT     = 15'b100000000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          count_reg;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          i_reg, i_next;
    logic [CNT_W-1:0]          j_reg, j_next;
    logic signed [DATA_W-1:0]  x_reg, x_next;
    logic signed [DATA_W-1:0]  xi_reg, xi_next;
    logic signed [DATA_W-1:0]  yi_reg, yi_next;
    logic signed [DATA_W-1:0]  b_reg, b_next;
    logic signed [DATA_W-1:0]  f_reg, f_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      sat_reg, sat_next;
    logic signed [DATA_W-1:0]  val_reg, val_next;
    logic [1:0]                stat_reg, stat_next;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [NODE_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  rd_x;
    logic signed [DATA_W-1:0]  rd_y;

    logic                      div_start;
    logic signed [DIFF_W-1:0]  num_diff;
    logic signed [DIFF_W-1:0]  den_diff;
    div_res_t                  div_res;

    logic signed [DATA_W-1:0]  mul_a;
    logic signed [DATA_W-1:0]  mul_b;
    logic signed [SUM_W-1:0]   quo_signed;
    logic [DATA_W:0]           f_clamp;
    logic [DATA_W:0]           b_clamp;
    logic [DATA_W:0]           sum_clamp;
    logic [CNT_W:0]            n_raw;

    // Node table: abscissa in the upper half, sample in the lower half.
    assign ram_we = item.valid && item.ready && (item.action == ACT_LOAD)
                    && (int'(item.node_index) < MAX_NODES);

    lie_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(item.node_index)),
        .wdata ({item.point_x, item.node_value}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[NODE_W-1:DATA_W];
    assign rd_y = ram_rdata[DATA_W-1:0];

    // Shared divider for every basis factor.
    assign num_diff = DIFF_W'(x_reg) - DIFF_W'(rd_x);
    assign den_diff = DIFF_W'(xi_reg) - DIFF_W'(rd_x);

    lie_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_diff (num_diff),
        .den_diff (den_diff),
        .res      (div_res)
    );

    // Shared multiplier: basis times factor, or sample times basis.
    assign mul_a = (state_reg == ST_MUL_B) ? b_reg : yi_reg;
    assign mul_b = (state_reg == ST_MUL_B) ? f_reg : b_reg;

    assign quo_signed = div_res.neg ? -$signed({1'b0, div_res.quo})
                                    : $signed({1'b0, div_res.quo});
    assign f_clamp    = clamp32(quo_signed);
    assign b_clamp    = clamp32(SUM_W'(round_q16(prod_reg)));
    assign sum_clamp  = clamp32(sum_reg);

    // Nodes in use, limited to the table depth.
    assign n_raw = (int'(count_reg) > MAX_NODES) ? (CNT_W + 1)'(MAX_NODES)
                                                 : (CNT_W + 1)'(count_reg);

    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = (state_reg == ST_OUT);
    assign result.interp_value = val_reg;
    assign result.status       = stat_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        xi_next    = xi_reg;
        yi_next    = yi_reg;
        b_next     = b_reg;
        f_next     = f_reg;
        prod_next  = prod_reg;
        sum_next   = sum_reg;
        sat_next   = sat_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        ram_raddr  = i_reg[IDX_W-1:0];
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid && item.action == ACT_EVAL)
                begin
                    n_next     = n_raw[CNT_W-1:0];
                    i_next     = '0;
                    x_next     = item.point_x;
                    sum_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_DUP_I;
                end
            end
            ST_DUP_I:
            begin
                if ((CNT_W + 1)'(i_reg) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(n_reg))
                begin
                    i_next     = '0;
                    state_next = ST_EV_I;
                end
                else
                begin
                    j_next     = i_reg + CNT_W'(1);
                    state_next = ST_DUP_J;
                end
            end
            ST_DUP_J:
            begin
                ram_raddr  = j_reg[IDX_W-1:0];
                xi_next    = rd_x;
                state_next = ST_DUP_CMP;
            end
            ST_DUP_CMP:
            begin
                // Read of the following node overlaps this compare.
                ram_raddr = IDX_W'(j_reg + CNT_W'(1));
                if (rd_x == xi_reg)
                begin
                    val_next   = '0;
                    stat_next  = STAT_DUP;
                    state_next = ST_OUT;
                end
                else if ((CNT_W + 1)'(j_reg) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(n_reg))
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_DUP_I;
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_EV_I:
            begin
                if (i_reg >= n_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    j_next     = '0;
                    b_next     = ONE_Q16;
                    state_next = ST_EV_XI;
                end
            end
            ST_EV_XI:
            begin
                xi_next    = rd_x;
                yi_next    = rd_y;
                state_next = ST_EV_J;
            end
            ST_EV_J:
            begin
                ram_raddr = j_reg[IDX_W-1:0];
                if (j_reg >= n_reg)
                begin
                    state_next = ST_MUL_T;
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EV_XJ;
                end
            end
            ST_EV_XJ:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    f_next     = f_clamp[DATA_W-1:0];
                    sat_next   = sat_reg | f_clamp[DATA_W];
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_RND_B;
            end
            ST_RND_B:
            begin
                b_next     = b_clamp[DATA_W-1:0];
                sat_next   = sat_reg | b_clamp[DATA_W];
                j_next     = j_reg + CNT_W'(1);
                state_next = ST_EV_J;
            end
            ST_MUL_T:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_RND_T;
            end
            ST_RND_T:
            begin
                sum_next   = sum_reg + SUM_W'(round_q16(prod_reg));
                i_next     = i_reg + CNT_W'(1);
                state_next = ST_EV_I;
            end
            ST_FIN:
            begin
                val_next   = sum_clamp[DATA_W-1:0];
                stat_next  = (sat_reg | sum_clamp[DATA_W]) ? STAT_SAT : STAT_OK;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= NODE_COUNT_RST;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            n_reg   <= n_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
            sat_reg <= sat_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        xi_reg   <= xi_next;
        yi_reg   <= yi_next;
        b_reg    <= b_next;
        f_reg    <= f_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        val_reg  <= val_next;
        stat_reg <= stat_next;
    end

endmodule

`default_nettype wire
